/* src/assert_macros.svh */
// assertion macros shared by the windowed deviation block
// no dependencies; clock clk_i and active-low reset rst_ni are assumed in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define WSS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define WSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* src/wss_pkg.sv */
// shared types and constants for the windowed deviation block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package wss_pkg;

  localparam int unsigned WINDOW_DEFAULT = 16;

  localparam logic [15:0]        MAX_DEV_RESET    = 16'd100;
  localparam logic signed [15:0] DRAW_LIMIT_RESET = 16'sd0;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W         = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DEVIATION = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DRAW_LIMIT    = 1'b1;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_UPD  = 9'b000000010,
    ST_ACC  = 9'b000000100,
    ST_MUL  = 9'b000001000,
    ST_SUB  = 9'b000010000,
    ST_SQRT = 9'b000100000,
    ST_MULR = 9'b001000000,
    ST_DIVQ = 9'b010000000,
    ST_FIN  = 9'b100000000
  } state_e;

  typedef struct packed {
    logic load;
    logic upd;
    logic acc;
    logic mul;
    logic sub;
    logic sqrt;
    logic mulr;
    logic divq;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic sqrt_last;
    logic out_busy;
  } status_t;

endpackage

`default_nettype wire

/* src/wss_ring.sv */
// sample ring: one write and one registered read of the overwritten slot per word
// uses no package items; slot 0 is also held in a register of its own
`timescale 1ns / 1ps
`default_nettype none

module wss_ring #(
  parameter int unsigned WINDOW = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               wr_en_i,
  input  wire logic signed [15:0] wr_data_i,
  output logic signed [15:0]      old_o,
  output logic signed [15:0]      slot0_o
);

  localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  logic signed [15:0] mem_q [WINDOW];
  logic signed [15:0] rd_q;
  logic               rd_valid_q;
  logic [WINDOW-1:0]  valid_q;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic signed [15:0] slot0_q;

  assign slot_d = (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + SLOT_W'(1);

  // read-before-write on the same slot gives the oldest sample
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[slot_q] <= wr_data_i;
      rd_q          <= mem_q[slot_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q     <= '0;
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
      slot0_q    <= '0;
    end else if (wr_en_i) begin
      slot_q          <= slot_d;
      valid_q[slot_q] <= 1'b1;
      rd_valid_q      <= valid_q[slot_q];
      if (slot_q == '0) begin
        slot0_q <= wr_data_i;
      end
    end
  end

  // a slot never written reads as zero
  assign old_o   = rd_valid_q ? rd_q : '0;
  assign slot0_o = slot0_q;

endmodule

`default_nettype wire

/* src/wss_dp.sv */
// datapath: running sums, variance numerator, bit-serial root, divide by window,
// stability compare, config registers and result register; uses wss_pkg, wss_ring
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module wss_dp #(
  parameter int unsigned WINDOW = wss_pkg::WINDOW_DEFAULT
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire wss_pkg::cmd_t                 cmd_i,
  output wss_pkg::status_t                   status_o,
  input  wire logic signed [15:0]            current_sample_i,
  input  wire logic                          cfg_valid_i,
  input  wire logic [wss_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [15:0]                   cfg_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [15:0]                        std_dev_o,
  output logic                               stable_o
);

  localparam int unsigned WB     = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W  = 16 + $clog2(WINDOW);
  localparam int unsigned SQ_W   = 31 + $clog2(WINDOW);
  localparam int unsigned NUM_W  = SQ_W + WB;
  localparam int unsigned ROOT_W = (NUM_W + 1) / 2;
  localparam int unsigned RAD_W  = 2 * ROOT_W;
  localparam int unsigned CNT_W  = $clog2(ROOT_W);
  // floor(2^ROOT_W / WINDOW); quotient estimate is at most one low
  localparam logic [ROOT_W-1:0] RECIP = ROOT_W'((64'd1 << ROOT_W) / WINDOW);

  // config
  logic [15:0]        max_dev_q;
  logic signed [15:0] draw_limit_q;

  // ring
  logic signed [15:0] old_w;
  logic signed [15:0] slot0_w;

  // sums
  logic signed [15:0]      sample_q;
  logic signed [SUM_W-1:0] sum_q;
  logic [30:0]             sq_new_q, sq_old_q;
  logic [SQ_W-1:0]         sumsq_q;
  logic [NUM_W-1:0]        wsq_q, sum2_q;
  logic signed [31:0]      sq_new_full, sq_old_full;
  logic signed [2*SUM_W-1:0] sum2_full;

  // root
  logic [RAD_W-1:0]  rad_q;
  logic [ROOT_W:0]   rem_q, rem_d;
  logic [ROOT_W-1:0] root_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [ROOT_W+2:0] trial_a, trial_b;
  logic              trial_ge;

  // divide
  logic [RAD_W-1:0]  prod_q;
  logic [ROOT_W-1:0] qest_w, qest_q, back_q, div_rem;
  logic [ROOT_W-1:0] dev_full;
  logic [15:0]       dev_w;
  logic [16:0]       limit_w;
  logic              stable_w;

  // result
  logic        out_valid_q;
  logic [15:0] std_dev_q;
  logic        stable_q;
  logic        gap_q;

  wss_ring #(
    .WINDOW (WINDOW)
  ) u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cmd_i.load),
    .wr_data_i (current_sample_i),
    .old_o     (old_w),
    .slot0_o   (slot0_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dev_q    <= wss_pkg::MAX_DEV_RESET;
      draw_limit_q <= wss_pkg::DRAW_LIMIT_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        wss_pkg::REG_MAX_DEVIATION: max_dev_q    <= cfg_data_i;
        wss_pkg::REG_DRAW_LIMIT:    draw_limit_q <= signed'(cfg_data_i);
      endcase
    end
  end

  assign sq_new_full = sample_q * sample_q;
  assign sq_old_full = old_w * old_w;
  assign sum2_full   = sum_q * sum_q;

  // one root bit a cycle, two radicand bits brought down each step
  assign trial_a  = {rem_q, rad_q[RAD_W-1 -: 2]};
  assign trial_b  = {1'b0, root_q, 2'b01};
  assign trial_ge = (trial_a >= trial_b);
  assign rem_d    = trial_ge ? (ROOT_W+1)'(trial_a - trial_b) : (ROOT_W+1)'(trial_a);

  assign qest_w   = prod_q[RAD_W-1:ROOT_W];
  assign div_rem  = root_q - back_q;
  assign dev_full = (div_rem >= ROOT_W'(WINDOW)) ? qest_q + ROOT_W'(1) : qest_q;
  assign dev_w    = (|dev_full[ROOT_W-1:16]) ? 16'hFFFF : dev_full[15:0];
  assign limit_w  = {1'b0, max_dev_q} + (gap_q ? {1'b0, max_dev_q} : 17'd0);
  assign stable_w = ({1'b0, dev_w} <= limit_w) && (slot0_w < draw_limit_q);

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sample_q <= current_sample_i;
    end
    if (cmd_i.upd) begin
      sq_new_q <= 31'(sq_new_full);
      sq_old_q <= 31'(sq_old_full);
    end
    if (cmd_i.mul) begin
      wsq_q  <= NUM_W'(sumsq_q) * NUM_W'(WINDOW);
      sum2_q <= NUM_W'(sum2_full);
    end
    if (cmd_i.sub) begin
      rad_q  <= (wsq_q >= sum2_q) ? RAD_W'(wsq_q - sum2_q) : '0;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.sqrt) begin
      rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= {root_q[ROOT_W-2:0], trial_ge};
    end
    if (cmd_i.mulr) begin
      prod_q <= RAD_W'(root_q) * RAD_W'(RECIP);
    end
    if (cmd_i.divq) begin
      qest_q <= qest_w;
      back_q <= ROOT_W'(qest_w * ROOT_W'(WINDOW));
    end
    if (cmd_i.fin) begin
      std_dev_q <= dev_w;
      stable_q  <= stable_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      sumsq_q     <= '0;
      cnt_q       <= '0;
      gap_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.upd) begin
        sum_q <= sum_q + SUM_W'(sample_q) - SUM_W'(old_w);
      end
      if (cmd_i.acc) begin
        sumsq_q <= sumsq_q + SQ_W'(sq_new_q) - SQ_W'(sq_old_q);
      end
      if (cmd_i.sub) begin
        cnt_q <= '0;
      end else if (cmd_i.sqrt) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (cmd_i.fin) begin
        gap_q       <= stable_w;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.sqrt_last = (cnt_q == CNT_W'(ROOT_W - 1));
  assign status_o.out_busy  = out_valid_q && out_stall_i;

  assign out_valid_o = out_valid_q;
  assign std_dev_o   = std_dev_q;
  assign stable_o    = stable_q;

  `WSS_ASSERT_NOW(a_no_overwrite, cmd_i.fin, !(out_valid_q && out_stall_i))
  `WSS_ASSERT_NOW(a_root_rem_bound, cmd_i.sqrt, {1'b0, rem_q} <= {root_q, 1'b0})

endmodule

`default_nettype wire

/* src/wss_ctrl.sv */
// controller: one-hot sequencer that steps the datapath through one word
// uses wss_pkg for states, commands and status
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module wss_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire wss_pkg::status_t status_i,
  output wss_pkg::cmd_t         cmd_o
);

  wss_pkg::state_e state_q, state_d;
  logic            accept;

  assign in_stall_o = (state_q != wss_pkg::ST_IDLE);
  assign accept     = in_valid_i && (state_q == wss_pkg::ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      wss_pkg::ST_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          state_d    = wss_pkg::ST_UPD;
        end
      end
      wss_pkg::ST_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = wss_pkg::ST_ACC;
      end
      wss_pkg::ST_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = wss_pkg::ST_MUL;
      end
      wss_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = wss_pkg::ST_SUB;
      end
      wss_pkg::ST_SUB: begin
        cmd_o.sub = 1'b1;
        state_d   = wss_pkg::ST_SQRT;
      end
      wss_pkg::ST_SQRT: begin
        cmd_o.sqrt = 1'b1;
        if (status_i.sqrt_last) begin
          state_d = wss_pkg::ST_MULR;
        end
      end
      wss_pkg::ST_MULR: begin
        cmd_o.mulr = 1'b1;
        state_d    = wss_pkg::ST_DIVQ;
      end
      wss_pkg::ST_DIVQ: begin
        cmd_o.divq = 1'b1;
        state_d    = wss_pkg::ST_FIN;
      end
      wss_pkg::ST_FIN: begin
        // hold the result until the output register is free
        if (!status_i.out_busy) begin
          cmd_o.fin = 1'b1;
          state_d   = wss_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = wss_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wss_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `WSS_ASSERT_NEXT(a_accept_to_upd, in_valid_i && !in_stall_o, state_q == wss_pkg::ST_UPD)
  `WSS_ASSERT_NEXT(a_sqrt_runs, state_q == wss_pkg::ST_SQRT && !status_i.sqrt_last,
                   state_q == wss_pkg::ST_SQRT)
  `WSS_ASSERT_NEXT(a_fin_waits, state_q == wss_pkg::ST_FIN && status_i.out_busy,
                   state_q == wss_pkg::ST_FIN)

endmodule

`default_nettype wire

/* src/windowed_stddev_stability_top.sv */
// flow: an accepted word steps through UPD, ACC, MUL, SUB, SQRT, MULR, DIVQ and FIN;
// SQRT resolves one root bit per cycle for ROOT_W bits, ROOT_W being half the variance
// numerator width, rounded up (20 for a window of 16); FIN waits while the output is held
// and registers the result; a new word is taken only once the block is back in IDLE
// reset: asynchronous, active low; ring slots read as zero at once, no clearing pass
// top level: joins controller and datapath; uses wss_pkg, wss_ctrl, wss_dp
`timescale 1ns / 1ps
`default_nettype none

module windowed_stddev_stability_top #(
  parameter int unsigned WINDOW = wss_pkg::WINDOW_DEFAULT
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic signed [15:0]            current_sample_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [15:0]                        std_dev_o,
  output logic                               stable_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [wss_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [15:0]                   cfg_data_i
);

  wss_pkg::cmd_t    cmd;
  wss_pkg::status_t status;

  // register writes are always accepted and registered directly
  assign cfg_ready_o = 1'b1;

  wss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  wss_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .current_sample_i (current_sample_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .std_dev_o        (std_dev_o),
    .stable_o         (stable_o)
  );

endmodule

`default_nettype wire

/* tb/sv/tb_windowed_stddev_stability_top.sv */
`timescale 1ns / 1ps
// self-checking bench for windowed_stddev_stability_top: sliding-window deviation
// and hysteretic stability flag, predicted in-bench and compared word by word
// depends on wss_pkg and the windowed_stddev_stability_top rtl
module tb_windowed_stddev_stability_top;

  localparam int unsigned WIN         = 16;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned IDLE_PCT    = 6;

  typedef struct packed {
    logic [15:0] std_dev;
    logic        stable;
  } window_result_t;

  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          in_valid  = 1'b0;
  logic                          in_stall;
  logic signed [15:0]            sample    = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [15:0]                   std_dev;
  logic                          stable;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [wss_pkg::CFG_IDX_W-1:0] cfg_index = wss_pkg::REG_MAX_DEVIATION;
  logic [15:0]                   cfg_data  = '0;

  // predicted window state and register copies
  logic signed [15:0] ring_q [WIN];
  int unsigned        slot_q;
  longint             sum_q;
  longint             sumsq_q;
  logic               gap_q;
  logic [15:0]        max_dev_q;
  logic signed [15:0] draw_limit_q;

  logic signed [15:0] samples_pending [$];
  window_result_t     results_due [$];
  int unsigned        mismatches  = 0;
  bit                 steady_flow = 1'b0;
  int unsigned        hold_asks   = 0;
  int unsigned        hold_seen   = 0;
  int unsigned        hold_left   = 0;

  always #2 clk = ~clk;

  windowed_stddev_stability_top #(
    .WINDOW(WIN)
  ) dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .current_sample_i(sample),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .std_dev_o       (std_dev),
    .stable_o        (stable),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  function automatic logic [15:0] int_root(input longint v);
    longint r;
    longint t;
    r = 0;
    for (int b = 15; b >= 0; b--) begin
      t = r | (longint'(1) << b);
      if (t * t <= v) r = t;
    end
    return r[15:0];
  endfunction

  // push one sample into the predicted ring and work out the deviation and flag
  function automatic window_result_t next_window(input logic signed [15:0] s);
    logic signed [15:0] old;
    longint             num;
    int                 limit;
    window_result_t     r;
    old            = ring_q[slot_q];
    ring_q[slot_q] = s;
    slot_q         = (slot_q + 1) % WIN;
    sum_q          = sum_q + longint'(s) - longint'(old);
    sumsq_q        = sumsq_q + longint'(s) * longint'(s) - longint'(old) * longint'(old);
    num            = longint'(WIN) * sumsq_q - sum_q * sum_q;
    if (num < 0) num = 0;
    r.std_dev = int_root(num / (longint'(WIN) * longint'(WIN)));
    // threshold plus gap at 17 bits, never wraps
    limit    = int'(max_dev_q) + (gap_q ? int'(max_dev_q) : 0);
    r.stable = (int'(r.std_dev) <= limit) && (ring_q[0] < draw_limit_q);
    gap_q    = r.stable;
    return r;
  endfunction

  function automatic logic signed [15:0] clip16(input int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // sample driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        results_due.push_back(next_window(sample));
        void'(samples_pending.pop_front());
      end
      if (!in_valid || !in_stall) begin
        if (samples_pending.size() > 0 &&
            (steady_flow || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid <= 1'b1;
          sample   <= samples_pending[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and output back-pressure
  always @(posedge clk) begin
    window_result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          $error("result word with none due: std_dev %0d stable %0b", std_dev, stable);
          mismatches++;
        end else begin
          want = results_due.pop_front();
          if (std_dev !== want.std_dev) begin
            $error("std_dev: expected %0d, actual %0d", want.std_dev, std_dev);
            mismatches++;
          end
          if (stable !== want.stable) begin
            $error("stable: expected %0b, actual %0b", want.stable, stable);
            mismatches++;
          end
        end
      end
      if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !steady_flow && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  task automatic write_reg(input logic [wss_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == wss_pkg::REG_MAX_DEVIATION) max_dev_q = val;
    else if (idx == wss_pkg::REG_DRAW_LIMIT) draw_limit_q = val;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (samples_pending.size() != 0 || results_due.size() != 0 || in_valid);
  endtask

  // runs of steady current with noise, raw random words and rail-to-rail swings
  task automatic queue_mixed(input int unsigned count);
    int          base;
    int          amp;
    int unsigned run;
    int unsigned left;
    int unsigned kind;
    left = count;
    while (left > 0) begin
      run  = $urandom_range(4, 20);
      if (run > left) run = left;
      kind = $urandom_range(9);
      base = ($urandom_range(1) == 0) ? int'($urandom_range(4000)) - 2000
                                      : int'($urandom_range(65535)) - 32768;
      amp  = ($urandom_range(3) == 0) ? int'($urandom_range(3000)) : int'($urandom_range(40));
      repeat (run) begin
        case (kind)
          0, 1: samples_pending.push_back(16'($urandom));
          2: samples_pending.push_back($urandom_range(1) ? 16'sh7FFF : 16'sh8000);
          default: samples_pending.push_back(
              clip16(base + int'($urandom_range(2 * amp)) - amp));
        endcase
      end
      left -= run;
    end
  endtask

  initial begin
    logic [15:0] dev_pick;
    logic [15:0] lim_pick;
    for (int k = 0; k < WIN; k++) ring_q[k] = '0;
    slot_q       = 0;
    sum_q        = 0;
    sumsq_q      = 0;
    gap_q        = 1'b0;
    max_dev_q    = wss_pkg::MAX_DEV_RESET;
    draw_limit_q = wss_pkg::DRAW_LIMIT_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // rail swings fill the zeroed ring for the widest deviation, then assorted corner words
    for (int k = 0; k < 16; k++) samples_pending.push_back(k[0] ? 16'sh8000 : 16'sh7FFF);
    samples_pending.push_back(16'sh7FFF);
    samples_pending.push_back(16'sh8000);
    samples_pending.push_back(16'sh0000);
    samples_pending.push_back(16'shFFFF);
    samples_pending.push_back(16'sh0001);
    samples_pending.push_back(16'sh5555);
    samples_pending.push_back(16'shAAAA);
    wait_drained();

    // widest threshold with the gap doubling it past 16 bits
    write_reg(wss_pkg::REG_MAX_DEVIATION, 16'hFFFF);
    write_reg(wss_pkg::REG_DRAW_LIMIT, 16'h7FFF);
    repeat (20) samples_pending.push_back(16'($urandom));
    wait_drained();

    // zero threshold: only a flat window with slot 0 at the bottom rail counts as stable
    write_reg(wss_pkg::REG_MAX_DEVIATION, 16'h0000);
    write_reg(wss_pkg::REG_DRAW_LIMIT, 16'h8001);
    repeat (16) samples_pending.push_back(16'sh8000);
    repeat (4) samples_pending.push_back(16'sh8001);
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(4))
        0: dev_pick = 16'h0000;
        1: dev_pick = 16'hFFFF;
        2: dev_pick = 16'($urandom_range(2000));
        default: dev_pick = 16'($urandom_range(40));
      endcase
      case ($urandom_range(4))
        0: lim_pick = 16'h8000;
        1: lim_pick = 16'h7FFF;
        2: lim_pick = 16'($urandom);
        default: lim_pick = 16'($urandom_range(4000) - 2000);
      endcase
      write_reg(wss_pkg::REG_MAX_DEVIATION, dev_pick);
      write_reg(wss_pkg::REG_DRAW_LIMIT, lim_pick);
      // one phase with the receiver held off so the block backs up into its input
      if (ph == 2) hold_asks++;
      steady_flow = (ph == 5);
      queue_mixed(48);
      wait_drained();
      steady_flow = 1'b0;
    end

    repeat (40) @(posedge clk);
    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
